>>> hdl/frame_group_completion_tracker_macros.svh
// assertion helpers for the frame group completion tracker
// both forms sample on clk and are disabled while rst_n is low
`ifndef FRAME_GROUP_COMPLETION_TRACKER_MACROS_SVH
`define FRAME_GROUP_COMPLETION_TRACKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FGCT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FGCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FGCT_ASSERT_SAME(lbl, ante, cons, msg)
`define FGCT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/fgct_pkg.sv
package fgct_pkg;

  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_LOCATE = 2'd1,
    REQ_INSERT = 2'd2,
    REQ_CHECK  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOC,
    ST_LOOK,
    ST_UPD,
    ST_FIN
  } state_t;

  localparam logic [1:0] CHK_INCOMPLETE = 2'd0;
  localparam logic [1:0] CHK_COMPLETE   = 2'd1;
  localparam logic [1:0] CHK_INVALID    = 2'd2;

  localparam int OFF_W  = 3;
  localparam int GRP_W  = 2;
  localparam int SLOT_W = 7;
  localparam int TOT_W  = 3;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 48;

  localparam logic [2:0] MAX_REPORT = 3'd4;
  localparam logic [7:0] FLAG_ONE   = 8'h01;
  localparam logic [OFF_W-1:0] OFF_BELOW = 3'b111;

endpackage

>>> hdl/frame_group_completion_tracker.sv
// frame group completion tracker
// in_* carries one request per transfer: in_tuser is the request kind (init, locate,
// insert, check), in_tdata the group index, base, frame counter, channel, position,
// reference index and start offset. out_* returns the results; out_tlast marks the
// final result of a request. insert gives one result per group that took the packet
// (up to four), or one all-zero result when none did.
// one request is worked at a time. check and a bad-index init go straight from
// acceptance to the finish state and the result register; locate takes one group
// step per cycle; insert does a read then a write-back of the frame row of each
// visited group in the row memory; a good init clears the group's FRAMES rows, one
// row a cycle, before its result. after reset a clearing pass walks all
// GROUPS*FRAMES rows of the row memory, one row a cycle, and no request is taken
// until it ends. the result register frees in_tready for the next request while a
// result waits; when the receiver stalls and a group result must be handed on, the
// walk holds in place until the register drains.
`include "frame_group_completion_tracker_macros.svh"

module frame_group_completion_tracker
  import fgct_pkg::*;
#(
  parameter int GROUPS         = 4,
  parameter int FRAMES         = 8,
  parameter int PKTS_PER_FRAME = 16,
  parameter int CHANNELS       = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // group_index, base_count, frame_counter, channel, position, ref_index, start_offset
  input  logic [111:0] in_tdata,
  // req_type
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // found_offset, hit_group, packet_slot, insert_total, check_status
  output logic [23:0]  out_tdata,
  output logic         out_tlast
);

  localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int IW    = (GW + 1 > 3) ? GW + 1 : 3;
  localparam int FW    = $clog2(FRAMES);
  localparam int ROWS  = GROUPS * FRAMES;
  localparam int AW    = $clog2(ROWS);
  localparam int CW    = $clog2(PKTS_PER_FRAME + 1);
  localparam int GPKTS = FRAMES * PKTS_PER_FRAME;
  localparam int GCW   = $clog2(GPKTS + 1);
  localparam int RW    = CHANNELS * 8 + CW;
  localparam int HW    = $clog2(GROUPS * (FRAMES - 1) + 1);
  localparam int TW    = $clog2(GROUPS + 1);

  // input fields
  logic [2:0]       in_gi;
  logic [CNT_W-1:0] in_base;
  logic [CNT_W-1:0] in_fc;
  logic [2:0]       in_ch;
  logic [2:0]       in_pos;
  logic [1:0]       in_ref;
  logic [1:0]       in_start;

  assign in_gi    = in_tdata[2:0];
  assign in_base  = in_tdata[50:3];
  assign in_fc    = in_tdata[98:51];
  assign in_ch    = in_tdata[101:99];
  assign in_pos   = in_tdata[104:102];
  assign in_ref   = in_tdata[106:105];
  assign in_start = in_tdata[108:107];

  // state
  state_t state_r, state_nxt;

  logic [CNT_W-1:0] gbase_r [GROUPS];
  logic [GCW-1:0]   gcnt_r  [GROUPS];
  logic [RW-1:0]    mem     [ROWS];
  logic [RW-1:0]    rd_r;

  logic [CNT_W-1:0] fc_r, fc_nxt;
  logic [2:0]       ch_r, ch_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic [GW-1:0]    ref_r, ref_nxt;
  logic [GW-1:0]    i_r, i_nxt;
  logic [GW-1:0]    g_r, g_nxt;
  logic             hit_r, hit_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [GW-1:0]    n_r, n_nxt;
  logic [HW-1:0]    hi_r, hi_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]    clr_end_r, clr_end_nxt;
  logic             init_pend_r, init_pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [GRP_W-1:0] pend_grp_r, pend_grp_nxt;
  logic [SLOT_W-1:0] pend_slot_r, pend_slot_nxt;
  logic [2:0]       rep_r, rep_nxt;
  logic [TW-1:0]    total_r, total_nxt;
  logic [OFF_W-1:0] res_off_r, res_off_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0]  out_off_r, out_off_nxt;
  logic [GRP_W-1:0]  out_grp_r, out_grp_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [TOT_W-1:0]  out_tot_r, out_tot_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_load;

  // handshake
  logic accept, out_free;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // index arithmetic on small ring indexes
  logic [IW-1:0] ref_ext, ref_mod, gi_ext, st_ext, gsum, gmod;
  logic [GW-1:0] ref_m, gi_idx, g_cur;
  logic          gi_ok, st_ok, i_last, n_last;

  always_comb begin
    ref_ext = IW'(in_ref);
    ref_mod = (ref_ext >= IW'(GROUPS)) ? ref_ext - IW'(GROUPS) : ref_ext;
    ref_m   = ref_mod[GW-1:0];
    gi_ext  = IW'(in_gi);
    gi_ok   = gi_ext < IW'(GROUPS);
    gi_idx  = gi_ext[GW-1:0];
    st_ext  = IW'(in_start);
    st_ok   = st_ext < IW'(GROUPS);
    gsum    = IW'(i_r) + IW'(ref_r);
    gmod    = (gsum >= IW'(GROUPS)) ? gsum - IW'(GROUPS) : gsum;
    g_cur   = gmod[GW-1:0];
    i_last  = IW'(i_r) == IW'(GROUPS - 1);
    n_last  = IW'(n_r) == IW'(GROUPS - 1);
  end

  // shared range subtract: reference group while locating, walked group while inserting
  logic [GW-1:0]    sel_g;
  logic [CNT_W:0]   diff;
  logic             in_range, loc_in;
  logic [AW-1:0]    row_addr;

  always_comb begin
    sel_g    = (state_r == ST_LOC) ? ref_r : g_cur;
    diff     = {1'b0, fc_r} - {1'b0, gbase_r[sel_g]};
    in_range = !diff[CNT_W] && (diff[CNT_W-1:0] < CNT_W'(FRAMES));
    loc_in   = diff[CNT_W-1:0] <= CNT_W'(hi_r);
    row_addr = AW'(g_cur * FRAMES) + AW'(diff[FW-1:0]);
  end

  // read-modify-write of one frame row
  logic [CW-1:0]  rd_cnt;
  logic [GCW-1:0] gc;
  logic           take, need_push, stall;
  logic [RW-1:0]  wr_row;

  always_comb begin
    rd_cnt    = rd_r[CW-1:0];
    gc        = gcnt_r[g_r];
    take      = hit_r && (rd_cnt < CW'(PKTS_PER_FRAME)) && (gc < GCW'(GPKTS));
    need_push = take && pend_v_r && (rep_r < MAX_REPORT);
    stall     = need_push && !out_free;
    wr_row    = rd_r;
    wr_row[CW-1:0] = rd_cnt + 1'b1;
    for (int c = 0; c < CHANNELS; c++) begin
      if (int'(ch_r) == c) begin
        wr_row[CW + c * 8 +: 8] = rd_r[CW + c * 8 +: 8] | (FLAG_ONE << pos_r);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == clr_end_r) state_nxt = init_pend_r ? ST_FIN : ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (req_t'(in_tuser))
            REQ_INIT:   state_nxt = gi_ok ? ST_CLEAR : ST_FIN;
            REQ_LOCATE: state_nxt = ST_LOC;
            REQ_INSERT: state_nxt = st_ok ? ST_LOOK : ST_FIN;
            REQ_CHECK:  state_nxt = ST_FIN;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end
      ST_LOC: begin
        if (diff[CNT_W] || loc_in || n_last) state_nxt = ST_FIN;
      end
      ST_LOOK: state_nxt = ST_UPD;
      ST_UPD: begin
        if (!stall) state_nxt = i_last ? ST_FIN : ST_LOOK;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and next values
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr;
  logic [RW-1:0]  mem_wdata;
  logic           gb_we, gc_we;
  logic [GW-1:0]  gc_idx;
  logic [GCW-1:0] gc_val;

  always_comb begin
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = wr_row;
    gb_we         = 1'b0;
    gc_we         = 1'b0;
    gc_idx        = g_r;
    gc_val        = gc + 1'b1;
    fc_nxt        = fc_r;
    ch_nxt        = ch_r;
    pos_nxt       = pos_r;
    ref_nxt       = ref_r;
    i_nxt         = i_r;
    g_nxt         = g_r;
    hit_nxt       = hit_r;
    addr_nxt      = addr_r;
    n_nxt         = n_r;
    hi_nxt        = hi_r;
    clr_addr_nxt  = clr_addr_r;
    clr_end_nxt   = clr_end_r;
    init_pend_nxt = init_pend_r;
    pend_v_nxt    = pend_v_r;
    pend_grp_nxt  = pend_grp_r;
    pend_slot_nxt = pend_slot_r;
    rep_nxt       = rep_r;
    total_nxt     = total_r;
    res_off_nxt   = res_off_r;
    res_stat_nxt  = res_stat_r;
    out_load      = 1'b0;
    out_off_nxt   = '0;
    out_grp_nxt   = pend_grp_r;
    out_slot_nxt  = pend_slot_r;
    out_tot_nxt   = '0;
    out_stat_nxt  = '0;
    out_last_nxt  = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          fc_nxt        = in_fc;
          ch_nxt        = in_ch;
          pos_nxt       = in_pos;
          ref_nxt       = ref_m;
          i_nxt         = st_ext[GW-1:0];
          n_nxt         = '0;
          hi_nxt        = HW'(FRAMES - 1);
          init_pend_nxt = 1'b0;
          pend_v_nxt    = 1'b0;
          pend_grp_nxt  = '0;
          pend_slot_nxt = '0;
          rep_nxt       = '0;
          total_nxt     = '0;
          res_off_nxt   = '0;
          res_stat_nxt  = CHK_INCOMPLETE;
          case (req_t'(in_tuser))
            REQ_INIT: begin
              if (gi_ok) begin
                gb_we         = 1'b1;
                gc_we         = 1'b1;
                gc_idx        = gi_idx;
                gc_val        = '0;
                init_pend_nxt = 1'b1;
                clr_addr_nxt  = AW'(gi_idx * FRAMES);
                clr_end_nxt   = AW'(gi_idx * FRAMES) + AW'(FRAMES - 1);
              end else begin
                res_stat_nxt = CHK_INVALID;
              end
            end
            REQ_CHECK: begin
              if (!gi_ok) res_stat_nxt = CHK_INVALID;
              else if (gcnt_r[gi_idx] == GCW'(GPKTS)) res_stat_nxt = CHK_COMPLETE;
              else res_stat_nxt = CHK_INCOMPLETE;
            end
            default: ;
          endcase
        end
      end
      ST_LOC: begin
        if (diff[CNT_W]) begin
          res_off_nxt = OFF_BELOW;
        end else if (loc_in || n_last) begin
          res_off_nxt = OFF_W'(n_r);
        end else begin
          n_nxt  = n_r + 1'b1;
          hi_nxt = hi_r + HW'(FRAMES - 1);
        end
      end
      ST_LOOK: begin
        mem_re   = 1'b1;
        hit_nxt  = in_range;
        addr_nxt = row_addr;
        g_nxt    = g_cur;
      end
      ST_UPD: begin
        if (!stall) begin
          i_nxt = i_r + 1'b1;
          if (take) begin
            mem_we    = 1'b1;
            gc_we     = 1'b1;
            total_nxt = total_r + 1'b1;
            // only the first four takers are reported, the fourth waits for last
            if (rep_r < MAX_REPORT) begin
              pend_v_nxt    = 1'b1;
              pend_grp_nxt  = GRP_W'(g_r);
              pend_slot_nxt = SLOT_W'(gc);
              rep_nxt       = rep_r + 1'b1;
              out_load      = pend_v_r;
            end
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_off_nxt  = res_off_r;
          out_tot_nxt  = TOT_W'(total_r);
          out_stat_nxt = res_stat_r;
          out_last_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    if (out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      clr_end_r   <= AW'(ROWS - 1);
      init_pend_r <= 1'b0;
      pend_v_r    <= 1'b0;
      rep_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        gbase_r[g] <= '0;
        gcnt_r[g]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_end_r   <= clr_end_nxt;
      init_pend_r <= init_pend_nxt;
      pend_v_r    <= pend_v_nxt;
      rep_r       <= rep_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (gb_we) gbase_r[gi_idx] <= in_base;
      if (gc_we) gcnt_r[gc_idx] <= gc_val;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fc_r        <= fc_nxt;
    ch_r        <= ch_nxt;
    pos_r       <= pos_nxt;
    ref_r       <= ref_nxt;
    i_r         <= i_nxt;
    g_r         <= g_nxt;
    hit_r       <= hit_nxt;
    addr_r      <= addr_nxt;
    n_r         <= n_nxt;
    hi_r        <= hi_nxt;
    pend_grp_r  <= pend_grp_nxt;
    pend_slot_r <= pend_slot_nxt;
    res_off_r   <= res_off_nxt;
    res_stat_r  <= res_stat_nxt;
    if (out_load) begin
      out_off_r  <= out_off_nxt;
      out_grp_r  <= out_grp_nxt;
      out_slot_r <= out_slot_nxt;
      out_tot_r  <= out_tot_nxt;
      out_stat_r <= out_stat_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // frame row memory: packet count in the low bits, one flag byte per channel above
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_r <= mem[row_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'b0, out_stat_r, out_tot_r, out_slot_r, out_grp_r, out_off_r};

  `FGCT_ASSERT_SAME(a_mem_we_state, mem_we, state_r == ST_UPD || state_r == ST_CLEAR, "row write outside update or clear")
  `FGCT_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, state_r != ST_IDLE, "request accepted but block stayed idle")
  `FGCT_ASSERT_SAME(a_rep_pend, rep_r != 3'd0, pend_v_r, "reported count without pending result")
  `FGCT_ASSERT_SAME(a_rep_total, pend_v_r, rep_r != 3'd0 && rep_r <= total_r, "report count exceeds taker count")
  `FGCT_ASSERT_SAME(a_last_fin, out_load && out_last_nxt, state_r == ST_FIN, "final result loaded outside finish")

endmodule

>>> tb/frame_group_completion_checker.sv
`timescale 1ns / 1ps

module frame_group_completion_checker
  import fgct_pkg::*;
#(
  parameter int GROUPS         = 4,
  parameter int FRAMES         = 8,
  parameter int PKTS_PER_FRAME = 16,
  parameter int CHANNELS       = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [23:0]  out_tdata,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending_count,
  output int           requests_seen,
  output int           results_seen,
  output int           completes_seen
);

  localparam int GROUP_CAP = FRAMES * PKTS_PER_FRAME;

  typedef struct packed {
    logic [OFF_W-1:0]  found_offset;
    logic [GRP_W-1:0]  hit_group;
    logic [SLOT_W-1:0] packet_slot;
    logic [TOT_W-1:0]  insert_total;
    logic [STAT_W-1:0] check_status;
    logic              last;
  } tracker_result_t;

  logic [CNT_W-1:0] group_start [GROUPS];
  logic [4:0]       frame_fill [GROUPS*FRAMES];
  logic [7:0]       chan_bits [GROUPS*FRAMES*CHANNELS];
  logic [7:0]       group_fill [GROUPS];

  tracker_result_t awaited_results [$];

  initial begin
    fail_count     = 0;
    pending_count  = 0;
    requests_seen  = 0;
    results_seen   = 0;
    completes_seen = 0;
  end

  // offset of the group covering fc, walking from group ri; no 48-bit wrap
  function automatic logic [OFF_W-1:0] locate_offset(int ri, logic [CNT_W-1:0] fc);
    logic [CNT_W+1:0] lo;
    logic [CNT_W+1:0] hi;
    logic [CNT_W+1:0] fc_wide;
    int n;
    lo = {2'b00, group_start[ri]};
    hi = lo + (FRAMES - 1);
    fc_wide = {2'b00, fc};
    if (fc_wide < lo) return OFF_BELOW;
    for (n = 0; n < GROUPS; n++) begin
      if (fc_wide >= lo && fc_wide <= hi) return OFF_W'(n);
      lo = lo + (FRAMES - 1);
      hi = hi + (FRAMES - 1);
    end
    return OFF_W'(GROUPS - 1);
  endfunction

  function automatic void apply_request(logic [1:0] user, logic [111:0] data);
    req_t             kind;
    logic [2:0]       gi;
    logic [CNT_W-1:0] base_v;
    logic [CNT_W-1:0] fc;
    logic [2:0]       ch;
    logic [2:0]       pos;
    int               ref_m;
    int               start;
    tracker_result_t  r;
    tracker_result_t  hits [4];
    int               nres;
    int               total;
    int               i;
    int               n;
    int               g;
    int               fi;
    logic [CNT_W+1:0] lo;
    logic [CNT_W+1:0] hi;
    logic [CNT_W+1:0] fc_wide;
    kind   = req_t'(user);
    gi     = data[2:0];
    base_v = data[50:3];
    fc     = data[98:51];
    ch     = data[101:99];
    pos    = data[104:102];
    ref_m  = int'(data[106:105]) % GROUPS;
    start  = int'(data[108:107]);
    fc_wide = {2'b00, fc};
    r = '0;
    r.last = 1'b1;
    case (kind)
      REQ_INIT: begin
        if (gi >= GROUPS) begin
          r.check_status = CHK_INVALID;
        end else begin
          group_start[gi] = base_v;
          for (n = 0; n < FRAMES; n++) frame_fill[gi*FRAMES + n] = '0;
          for (n = 0; n < FRAMES*CHANNELS; n++) chan_bits[gi*FRAMES*CHANNELS + n] = '0;
          group_fill[gi] = '0;
        end
        awaited_results.push_back(r);
      end
      REQ_LOCATE: begin
        r.found_offset = locate_offset(ref_m, fc);
        awaited_results.push_back(r);
      end
      REQ_INSERT: begin
        nres  = 0;
        total = 0;
        for (i = start; i < GROUPS; i++) begin
          g  = (i + ref_m) % GROUPS;
          lo = {2'b00, group_start[g]};
          hi = lo + (FRAMES - 1);
          if (fc_wide >= lo && fc_wide <= hi) begin
            fi = g*FRAMES + int'(fc_wide - lo);
            if (frame_fill[fi] < PKTS_PER_FRAME && group_fill[g] < GROUP_CAP) begin
              frame_fill[fi] = frame_fill[fi] + 1'b1;
              if (ch < CHANNELS) chan_bits[fi*CHANNELS + ch] |= FLAG_ONE << pos;
              if (nres < int'(MAX_REPORT)) begin
                hits[nres] = '0;
                hits[nres].hit_group   = GRP_W'(g);
                hits[nres].packet_slot = group_fill[g][SLOT_W-1:0];
                nres++;
              end
              group_fill[g] = group_fill[g] + 1'b1;
              total++;
            end
          end
        end
        if (nres == 0) begin
          awaited_results.push_back(r);
        end else begin
          hits[nres-1].insert_total = TOT_W'(total);
          hits[nres-1].last = 1'b1;
          for (n = 0; n < nres; n++) awaited_results.push_back(hits[n]);
        end
      end
      default: begin
        if (gi >= GROUPS) begin
          r.check_status = CHK_INVALID;
        end else if (group_fill[gi] == GROUP_CAP) begin
          r.check_status = CHK_COMPLETE;
          completes_seen++;
        end else begin
          r.check_status = CHK_INCOMPLETE;
        end
        awaited_results.push_back(r);
      end
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void match_result(logic [23:0] data, logic lastbit);
    tracker_result_t want;
    tracker_result_t got;
    got.found_offset = data[2:0];
    got.hit_group    = data[4:3];
    got.packet_slot  = data[11:5];
    got.insert_total = data[14:12];
    got.check_status = data[16:15];
    got.last         = lastbit;
    if (awaited_results.size() == 0) begin
      $error("result with nothing pending: tdata %h tlast %b", data, lastbit);
      fail_count++;
      return;
    end
    want = awaited_results.pop_front();
    check_field("found_offset", want.found_offset, got.found_offset);
    check_field("hit_group", want.hit_group, got.hit_group);
    check_field("packet_slot", want.packet_slot, got.packet_slot);
    check_field("insert_total", want.insert_total, got.insert_total);
    check_field("check_status", want.check_status, got.check_status);
    check_field("last", want.last, got.last);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < GROUPS; k++) begin
        group_start[k] = '0;
        group_fill[k]  = '0;
      end
      for (int k = 0; k < GROUPS*FRAMES; k++) frame_fill[k] = '0;
      for (int k = 0; k < GROUPS*FRAMES*CHANNELS; k++) chan_bits[k] = '0;
      awaited_results.delete();
    end else begin
      // results leave before the request taken on this edge can produce any
      if (out_tvalid && out_tready) begin
        match_result(out_tdata, out_tlast);
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        apply_request(in_tuser, in_tdata);
        requests_seen++;
      end
    end
    pending_count = awaited_results.size();
  end

endmodule

>>> tb/tb_frame_group_completion_tracker.sv
`timescale 1ns / 1ps

module tb_frame_group_completion_tracker;
  import fgct_pkg::*;

  localparam int GROUPS         = 4;
  localparam int FRAMES         = 8;
  localparam int PKTS_PER_FRAME = 16;
  localparam int CHANNELS       = 8;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 300;
  localparam logic [47:0] TOP48 = 48'hFFFF_FFFF_FFFF;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [23:0]  out_tdata;
  logic         out_tlast;

  int fail_count;
  int pending_count;
  int requests_seen;
  int results_seen;
  int completes_seen;

  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_pending;
  int hold_left;
  int cycle_count;

  frame_group_completion_tracker #(
    .GROUPS(GROUPS), .FRAMES(FRAMES), .PKTS_PER_FRAME(PKTS_PER_FRAME), .CHANNELS(CHANNELS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  frame_group_completion_checker #(
    .GROUPS(GROUPS), .FRAMES(FRAMES), .PKTS_PER_FRAME(PKTS_PER_FRAME), .CHANNELS(CHANNELS)
  ) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .fail_count(fail_count), .pending_count(pending_count), .requests_seen(requests_seen),
    .results_seen(results_seen), .completes_seen(completes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic [111:0] pack_req(logic [2:0] gi, logic [47:0] base,
                                            logic [47:0] fc, logic [2:0] ch,
                                            logic [2:0] pos, logic [1:0] ref_i,
                                            logic [1:0] start);
    return {3'b000, start, ref_i, pos, ch, fc, base, gi};
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_req(req_t kind, logic [111:0] fields);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= fields;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_directed();
    // nothing set up yet, then bad group indexes
    send_req(REQ_CHECK, pack_req(3'd0, '0, '0, 3'd0, 3'd0, 2'd0, 2'd0));
    send_req(REQ_CHECK, pack_req(3'd7, '0, '0, 3'd0, 3'd0, 2'd0, 2'd0));
    send_req(REQ_CHECK, pack_req(3'd4, '0, '0, 3'd0, 3'd0, 2'd0, 2'd0));
    send_req(REQ_INIT, pack_req(3'd5, 48'd55, '0, 3'd0, 3'd0, 2'd0, 2'd0));
    // contiguous window, neighbours share one frame
    send_req(REQ_INIT, pack_req(3'd0, 48'd100, '0, 3'd0, 3'd0, 2'd0, 2'd0));
    send_req(REQ_INIT, pack_req(3'd1, 48'd107, '0, 3'd0, 3'd0, 2'd0, 2'd0));
    send_req(REQ_INIT, pack_req(3'd2, 48'd114, '0, 3'd0, 3'd0, 2'd0, 2'd0));
    send_req(REQ_INIT, pack_req(3'd3, 48'd121, '0, 3'd0, 3'd0, 2'd0, 2'd0));
    // below, first, shared, second, past the end, below from another reference
    send_req(REQ_LOCATE, pack_req(3'd0, '0, 48'd99, 3'd0, 3'd0, 2'd0, 2'd0));
    send_req(REQ_LOCATE, pack_req(3'd0, '0, 48'd100, 3'd0, 3'd0, 2'd0, 2'd0));
    send_req(REQ_LOCATE, pack_req(3'd0, '0, 48'd107, 3'd0, 3'd0, 2'd0, 2'd0));
    send_req(REQ_LOCATE, pack_req(3'd0, '0, 48'd108, 3'd0, 3'd0, 2'd0, 2'd0));
    send_req(REQ_LOCATE, pack_req(3'd0, '0, 48'd129, 3'd0, 3'd0, 2'd0, 2'd0));
    send_req(REQ_LOCATE, pack_req(3'd0, '0, 48'd0, 3'd0, 3'd0, 2'd3, 2'd0));
    // shared frame hits two groups, start offset skips one, then no taker
    send_req(REQ_INSERT, pack_req(3'd0, '0, 48'd107, 3'd2, 3'd5, 2'd0, 2'd0));
    send_req(REQ_INSERT, pack_req(3'd0, '0, 48'd107, 3'd3, 3'd1, 2'd0, 2'd1));
    send_req(REQ_INSERT, pack_req(3'd0, '0, 48'd50, 3'd1, 3'd1, 2'd0, 2'd0));
    send_req(REQ_INSERT, pack_req(3'd0, '0, 48'd121, 3'd0, 3'd0, 2'd1, 2'd2));
    // base at the very top must not wrap
    send_req(REQ_INIT, pack_req(3'd3, TOP48, '0, 3'd0, 3'd0, 2'd0, 2'd0));
    send_req(REQ_INSERT, pack_req(3'd0, '0, TOP48, 3'd7, 3'd7, 2'd3, 2'd0));
    send_req(REQ_LOCATE, pack_req(3'd0, '0, TOP48, 3'd0, 3'd0, 2'd3, 2'd0));
    send_req(REQ_CHECK, pack_req(3'd3, '0, '0, 3'd0, 3'd0, 2'd0, 2'd0));
  endtask

  // one window of overlapping groups, then mostly inserts into it
  task automatic run_traffic(int count);
    logic [47:0] wbase;
    logic [47:0] fc;
    logic [2:0]  gi;
    logic [1:0]  wref;
    logic [1:0]  ref_i;
    logic [1:0]  start;
    int          pick;
    int          k;
    int          slot_k;
    if ($urandom_range(3) == 0) wbase = TOP48 - 48'($urandom_range(40));
    else wbase = rand48() >> $urandom_range(47);
    wref = 2'($urandom_range(3));
    for (k = 0; k < GROUPS; k++) begin
      send_req(REQ_INIT, pack_req(3'((int'(wref) + k) % GROUPS), wbase + 48'(7 * k),
                                  rand48(), 3'($urandom_range(7)), 3'($urandom_range(7)),
                                  2'($urandom_range(3)), 2'($urandom_range(3))));
    end
    for (k = GROUPS; k < count; k++) begin
      pick  = $urandom_range(99);
      fc    = wbase + 48'($urandom_range(30)) - 48'd2;
      ref_i = ($urandom_range(4) == 0) ? 2'($urandom_range(3)) : wref;
      start = ($urandom_range(1) == 0) ? 2'd0 : 2'($urandom_range(3));
      gi    = 3'($urandom_range(7));
      if (pick < 60) begin
        send_req(REQ_INSERT, pack_req(gi, rand48(), fc, 3'($urandom_range(7)),
                                      3'($urandom_range(7)), ref_i, start));
      end else if (pick < 72) begin
        send_req(REQ_LOCATE, pack_req(gi, rand48(), fc, 3'($urandom_range(7)),
                                      3'($urandom_range(7)), 2'($urandom_range(3)), start));
      end else if (pick < 82) begin
        send_req(REQ_CHECK, pack_req(gi, rand48(), fc, 3'($urandom_range(7)),
                                     3'($urandom_range(7)), ref_i, start));
      end else if (pick < 88) begin
        slot_k = (int'(gi) - int'(wref) + 8) % GROUPS;
        send_req(REQ_INIT, pack_req(gi, ($urandom_range(1) == 0) ? wbase + 48'(7 * slot_k)
                                                                 : rand48(),
                                    fc, 3'($urandom_range(7)), 3'($urandom_range(7)),
                                    ref_i, start));
      end else begin
        send_req(req_t'($urandom_range(3)),
                 pack_req(gi, rand48(), rand48(), 3'($urandom_range(7)),
                          3'($urandom_range(7)), 2'($urandom_range(3)),
                          2'($urandom_range(3))));
      end
    end
  endtask

  // pushes one group past every frame limit until it reports complete
  task automatic fill_group();
    logic [2:0]  gi;
    logic [47:0] fbase;
    int          f;
    int          n;
    gi    = 3'($urandom_range(GROUPS - 1));
    fbase = rand48() >> $urandom_range(47);
    send_req(REQ_INIT, pack_req(gi, fbase, '0, 3'd0, 3'd0, 2'd0, 2'd0));
    for (f = 0; f < FRAMES; f++) begin
      // one more than a frame holds, the last one is turned away
      for (n = 0; n <= PKTS_PER_FRAME; n++) begin
        send_req(REQ_INSERT, pack_req(3'($urandom_range(7)), rand48(), fbase + 48'(f),
                                      3'($urandom_range(7)), 3'($urandom_range(7)),
                                      2'($urandom_range(3)), 2'd0));
      end
    end
    send_req(REQ_CHECK, pack_req(gi, '0, '0, 3'd0, 3'd0, 2'd0, 2'd0));
  endtask

  // receiver side, with one long hold-off
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = REQ_INIT;
    hold_pending = 1'b0;
    tx_idle_pct  = 19;
    rx_idle_pct  = 87;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    repeat (2) run_traffic(45);

    tx_idle_pct = 87;
    rx_idle_pct = 19;
    repeat (2) run_traffic(45);

    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_pending = 1'b1;
    fill_group();
    run_traffic(45);
    in_tvalid <= 1'b0;

    wait (pending_count == 0);
    repeat (4 * FRAMES) @(posedge clk);

    $display("covered %0d requests and %0d results, %0d checks of a full group",
             requests_seen, results_seen, completes_seen);
    $display("under sender-heavy, receiver-heavy and no idling, plus one long output hold");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/fgct_pkg.sv
hdl/frame_group_completion_tracker.sv
tb/frame_group_completion_checker.sv
tb/tb_frame_group_completion_tracker.sv
